### rtl/core/ord_pkg.sv
// Package for the overwriting ring deque: sizes, operation codes, the decoded
// command type and the command channel between the front and the back.
// No dependencies.
package ord_pkg;

    localparam int CAPACITY = 16;
    localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W    = $clog2(CAPACITY + 1);

    localparam int FUNC_W  = 3;
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 8;
    localparam int FILL_W  = 5;

    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ       = 3'd4;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [OCC_W-1:0] occ_t;
    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [2:0] {
        OP_PUSH_BACK,
        OP_PUSH_FRONT,
        OP_POP_BACK,
        OP_POP_FRONT,
        OP_READ,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t   op;
        data_t value;
        ptr_t  slot;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_chan_t;

endpackage

### rtl/core/ord_req_if.sv
// Request channel of the ring deque: valid, ready and one operation beat.
// Depends on ord_pkg for the field widths.
interface ord_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [ord_pkg::FUNC_W-1:0]            func;
    logic signed [ord_pkg::DATA_W-1:0]     push_value;
    logic [ord_pkg::INDEX_W-1:0]           slot_index;

    modport source (output valid, output func, output push_value, output slot_index,
                    input ready);
    modport sink (input valid, input func, input push_value, input slot_index,
                  output ready);
endinterface

### rtl/core/ord_rsp_if.sv
// Response channel of the ring deque: valid, ready and one result beat.
// Depends on ord_pkg for the field widths.
interface ord_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ord_pkg::DATA_W-1:0]     read_data;
    logic [ord_pkg::FILL_W-1:0]            fill_count;

    modport source (output valid, output read_data, output fill_count, input ready);
    modport sink (input valid, input read_data, input fill_count, output ready);
endinterface

### rtl/core/ord_front.sv
// Front end of the ring deque: accepts request beats, decodes the operation,
// clamps the read index and queues the command in a two-entry queue.
// Depends on ord_pkg and ord_req_if.
module ord_front (
    input  logic               clk,
    input  logic               rst_n,
    ord_req_if.sink            req,
    output ord_pkg::cmd_chan_t cmd_out,
    input  logic               cmd_ready
);
    import ord_pkg::*;

    localparam int QDEPTH = 2;

    cmd_t        entries_reg [QDEPTH];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    cmd_t        decoded;
    logic        push;
    logic        pop;

    always_comb
    begin
        decoded.value = req.push_value;
        if ({1'b0, req.slot_index} >= 9'(CAPACITY))
        begin
            decoded.slot = PTR_W'(CAPACITY - 1);
        end
        else
        begin
            decoded.slot = req.slot_index[PTR_W-1:0];
        end
        case (req.func)
            FUNC_PUSH_BACK:  decoded.op = OP_PUSH_BACK;
            FUNC_PUSH_FRONT: decoded.op = OP_PUSH_FRONT;
            FUNC_POP_BACK:   decoded.op = OP_POP_BACK;
            FUNC_POP_FRONT:  decoded.op = OP_POP_FRONT;
            FUNC_READ:       decoded.op = OP_READ;
            default:         decoded.op = OP_NONE;
        endcase
    end

    assign req.ready     = (count_reg != 2'(QDEPTH));
    assign push          = req.valid && req.ready;
    assign cmd_out.valid = (count_reg != 2'd0);
    assign cmd_out.cmd   = entries_reg[rd_ptr_reg];
    assign pop           = cmd_out.valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= decoded;
        end
    end

    // The queue never holds more than its two entries.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 2'(QDEPTH))
        else $error("command queue overflow");

    // Pointers differ by the fill level: equal when empty or full, apart when one is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");

    // An accepted beat with nothing leaving raises the count by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count did not follow a write");

endmodule

### rtl/core/ord_back.sv
// Back end of the ring deque: holds the slots, the head and tail pointers and
// the occupancy, carries out one command per cycle unless rsp stalls, and
// registers the result. Depends on ord_pkg and ord_rsp_if.
module ord_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ord_pkg::cmd_chan_t cmd_in,
    output logic               cmd_ready,
    ord_rsp_if.source          rsp
);
    import ord_pkg::*;

    data_t  slots_reg [CAPACITY];
    ptr_t   head_reg;
    ptr_t   head_next;
    ptr_t   tail_reg;
    ptr_t   tail_next;
    occ_t   occ_reg;
    occ_t   occ_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    data_t  read_data_reg;
    logic [FILL_W-1:0] fill_reg;
    logic   exec;
    logic   wr_en;
    ptr_t   wr_addr;
    data_t  wr_data;
    data_t  rd_data;
    ptr_t   step_tail;
    ptr_t   step_head;

    function automatic ptr_t step_up(input ptr_t p);
        return (p == PTR_W'(CAPACITY - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic ptr_t step_down(input ptr_t p);
        return (p == '0) ? PTR_W'(CAPACITY - 1) : p - PTR_W'(1);
    endfunction

    assign cmd_ready = !rsp_valid_reg || rsp.ready;
    assign exec      = cmd_in.valid && cmd_ready;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        wr_en     = 1'b0;
        wr_addr   = head_reg;
        wr_data   = cmd_in.cmd.value;
        rd_data   = '0;
        step_tail = step_up(tail_reg);
        step_head = step_down(head_reg);
        case (cmd_in.cmd.op)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                wr_en = 1'b1;
                if (occ_reg == '0)
                begin
                    // First element: both ends sit on the head slot.
                    tail_next = head_reg;
                    occ_next  = OCC_W'(1);
                end
                else if (cmd_in.cmd.op == OP_PUSH_BACK)
                begin
                    tail_next = step_tail;
                    wr_addr   = step_tail;
                    if (step_tail == head_reg)
                    begin
                        head_next = step_up(head_reg);
                    end
                    else
                    begin
                        occ_next = occ_reg + OCC_W'(1);
                    end
                end
                else
                begin
                    head_next = step_head;
                    wr_addr   = step_head;
                    if (step_head == tail_reg)
                    begin
                        tail_next = step_down(tail_reg);
                    end
                    else
                    begin
                        occ_next = occ_reg + OCC_W'(1);
                    end
                end
            end
            OP_POP_BACK:
            begin
                if (occ_reg != '0)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = tail_reg;
                    wr_data   = '0;
                    occ_next  = occ_reg - OCC_W'(1);
                    tail_next = step_down(tail_reg);
                end
            end
            OP_POP_FRONT:
            begin
                if (occ_reg != '0)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = head_reg;
                    wr_data   = '0;
                    occ_next  = occ_reg - OCC_W'(1);
                    head_next = step_up(head_reg);
                end
            end
            OP_READ:
            begin
                rd_data = slots_reg[cmd_in.cmd.slot];
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (exec)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                slots_reg[i] <= '0;
            end
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (exec)
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                occ_reg  <= occ_next;
                if (wr_en)
                begin
                    slots_reg[wr_addr] <= wr_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            read_data_reg <= rd_data;
            fill_reg      <= FILL_W'(occ_next);
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_data  = read_data_reg;
    assign rsp.fill_count = fill_reg;

    assert property (@(posedge clk) disable iff (!rst_n) occ_reg <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

    // With a single element both ends point at it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == OCC_W'(1)) |-> (head_reg == tail_reg))
        else $error("head and tail apart with one element");

    // A push into a full ring keeps it full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (exec && occ_reg == OCC_W'(CAPACITY)
         && (cmd_in.cmd.op == OP_PUSH_BACK || cmd_in.cmd.op == OP_PUSH_FRONT))
        |=> (occ_reg == OCC_W'(CAPACITY)))
        else $error("overwrite changed occupancy");

    // Occupancy moves by at most one per command.
    assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> (occ_reg == $past(occ_reg) || occ_reg == $past(occ_reg) + OCC_W'(1)
                  || occ_reg == $past(occ_reg) - OCC_W'(1)))
        else $error("occupancy jumped");

endmodule

### rtl/core/overwriting_ring_deque_top.sv
// Top level of the overwriting ring deque: joins the decoding front end and the
// executing back end through the command channel.
// Depends on ord_pkg, ord_req_if, ord_rsp_if, ord_front and ord_back.
//
// Usage: each beat on req carries func (push back, push front, pop back,
// pop front, read slot), push_value and slot_index. Every accepted beat gives
// exactly one beat on rsp with read_data (slot contents for a read, zero
// otherwise) and fill_count, the occupancy after the operation. A push into a
// full ring overwrites the element at the opposite end; a pop of an empty ring
// changes nothing; a pop clears the vacated slot to zero. An index at or above
// the capacity reads the last slot.
// An accepted beat passes through the command queue and then the output
// register before it is offered on rsp. Throughput is one beat per cycle while
// rsp.ready holds: a two-entry command queue feeds the back end, which finishes
// one command per cycle into a single output register.
// Reset clears the slots, both pointers, the occupancy and the queue.
// When the receiver stalls, the output register holds its beat, the back end
// stops, and the queue fills up to its two entries before req.ready drops.
module overwriting_ring_deque_top (
    input logic      clk,
    input logic      rst_n,
    ord_req_if.sink  req,
    ord_rsp_if.source rsp
);
    import ord_pkg::*;

    cmd_chan_t cmd;
    logic      cmd_ready;

    ord_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_out   (cmd),
        .cmd_ready (cmd_ready)
    );

    ord_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_in    (cmd),
        .cmd_ready (cmd_ready),
        .rsp       (rsp)
    );

endmodule
